FILE: rtl/sensor_stats_tracker_assert.svh
// assertion macros for the sensor stats tracker
`ifndef SENSOR_STATS_TRACKER_ASSERT_SVH
`define SENSOR_STATS_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SST_ASSERT(lbl, prop, msg)

`define SST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/sst_pkg.sv
package sst_pkg;

    localparam int SF_SET_DEPTH_DEF = 16;
    localparam int SITE_COUNT_DEF   = 2;
    localparam int SOURCE_COUNT_DEF = 2;

    localparam int VAL_W      = 32;
    localparam int TIME_W     = 40;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 32;
    localparam int DIST_W     = 5;
    localparam int SF_W       = 8;
    localparam int ALU_W      = 49;
    localparam int STAT_KINDS = 3;

    localparam logic [2:0] KIND_BATTERY = 3'd3;
    localparam logic [2:0] KIND_SF      = 3'd4;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    site;
        logic [2:0]              kind;
        logic signed [VAL_W-1:0] measure_value;
        logic [TIME_W-1:0]       time_stamp;
        logic                    source_file;
    } t_req;

    typedef struct packed {
        logic                    accepted;
        logic                    sf_recorded;
        logic signed [VAL_W-1:0] low_value;
        logic [TIME_W-1:0]       low_time;
        logic signed [VAL_W-1:0] high_value;
        logic [TIME_W-1:0]       high_time;
        logic signed [SUM_W-1:0] running_sum;
        logic [CNT_W-1:0]        running_count;
        logic [DIST_W-1:0]       distinct_count;
        logic [TIME_W-1:0]       period_first;
        logic [TIME_W-1:0]       period_last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PER_FIRST,
        S_PER_LAST,
        S_STAT_HIGH,
        S_STAT_LOW,
        S_STAT_SUM,
        S_BAT_FIRST,
        S_BAT_LAST,
        S_SF_START,
        S_SF_CMP,
        S_SF_WR,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

FILE: rtl/sensor_stats_tracker.sv
// channel   signals                               direction
// request   i_in_valid, o_in_stall, i_in_req      in
// result    o_out_valid, i_out_stall, o_out_rsp   out
//
// the spreading factor set walk is the longest part of a request: one stored entry per
// cycle out of the set RAM through the shared 49-bit add/compare unit
// min/max, sum, battery and period updates each take one pass of that unit
// reset is synchronous; the set RAM is not cleared, the fill counts are
// o_in_stall is high during reset and while a request is in flight
// a finished result waits in S_DONE, with o_in_stall high, while i_out_stall holds the output register
`include "sensor_stats_tracker_assert.svh"

module sensor_stats_tracker #(
    parameter int SF_SET_DEPTH = sst_pkg::SF_SET_DEPTH_DEF,
    parameter int SITE_COUNT   = sst_pkg::SITE_COUNT_DEF,
    parameter int SOURCE_COUNT = sst_pkg::SOURCE_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sst_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sst_pkg::t_rsp o_out_rsp
);

    import sst_pkg::*;

    localparam int STAT_SLOTS = SITE_COUNT * STAT_KINDS;
    localparam int SF_TOTAL   = SITE_COUNT * SF_SET_DEPTH;
    localparam int SITE_W     = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
    localparam int SRC_W      = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int K_W        = $clog2(STAT_SLOTS);
    localparam int IDX_W      = (SF_SET_DEPTH > 1) ? $clog2(SF_SET_DEPTH) : 1;
    localparam int FILL_W     = $clog2(SF_SET_DEPTH + 1);
    localparam int ADDR_W     = (SF_TOTAL > 1) ? $clog2(SF_TOTAL) : 1;

    function automatic logic [ALU_W-1:0] ext_time(input logic [TIME_W-1:0] t);
        ext_time = {{(ALU_W-TIME_W){1'b0}}, t};
    endfunction

    function automatic logic [ALU_W-1:0] ext_val(input logic [VAL_W-1:0] v);
        ext_val = {{(ALU_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] ext_sf(input logic [SF_W-1:0] s);
        ext_sf = {{(ALU_W-SF_W){1'b0}}, s};
    endfunction

    t_state r_state, n_state;
    t_req   r_item;
    t_rsp   r_out_rsp, n_out_rsp;
    logic   r_out_valid;
    logic   r_sf_rec;

    logic signed [VAL_W-1:0] r_stat_low_value  [STAT_SLOTS];
    logic [TIME_W-1:0]       r_stat_low_time   [STAT_SLOTS];
    logic signed [VAL_W-1:0] r_stat_high_value [STAT_SLOTS];
    logic [TIME_W-1:0]       r_stat_high_time  [STAT_SLOTS];
    logic signed [SUM_W-1:0] r_stat_sum        [STAT_SLOTS];
    logic [CNT_W-1:0]        r_stat_count      [STAT_SLOTS];

    logic                    r_bat_seen        [SITE_COUNT];
    logic signed [VAL_W-1:0] r_bat_first_value [SITE_COUNT];
    logic [TIME_W-1:0]       r_bat_first_time  [SITE_COUNT];
    logic signed [VAL_W-1:0] r_bat_last_value  [SITE_COUNT];
    logic [TIME_W-1:0]       r_bat_last_time   [SITE_COUNT];
    logic [FILL_W-1:0]       r_sf_fill         [SITE_COUNT];

    logic                    r_per_seen  [SOURCE_COUNT];
    logic [TIME_W-1:0]       r_per_start [SOURCE_COUNT];
    logic [TIME_W-1:0]       r_per_end   [SOURCE_COUNT];

    logic [IDX_W-1:0] r_idx, n_idx;

    logic [SITE_W-1:0] site_idx;
    logic [SRC_W-1:0]  src_idx;
    logic [K_W-1:0]    stat_k;
    logic              site_ok, src_ok, item_ok, per_en, stat_first;
    logic              ip_ok;
    logic [SF_W-1:0]   ip;
    logic [FILL_W-1:0] fill_cur;
    logic              sf_last, sf_room;
    logic              accept, load_out;
    t_state            kind_route;

    t_alu_op           alu_op;
    logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_neg, alu_zero;
    logic [SUM_W-1:0]  sum_sat;

    logic              ram_we;
    logic [ADDR_W-1:0] sf_base, ram_waddr, ram_raddr;
    logic [SF_W-1:0]   ram_rdata;

    // decode of the held request
    assign site_idx   = SITE_W'(r_item.site);
    assign src_idx    = SRC_W'(r_item.source_file);
    assign site_ok    = 32'(r_item.site) < 32'(SITE_COUNT);
    assign src_ok     = 32'(r_item.source_file) < 32'(SOURCE_COUNT);
    assign item_ok    = site_ok && (r_item.kind <= KIND_SF);
    assign per_en     = item_ok && src_ok;
    assign stat_k     = K_W'(site_idx) * K_W'(STAT_KINDS) + K_W'(r_item.kind);
    assign stat_first = (r_stat_count[stat_k] == '0);

    // integer part truncated toward zero, kept only in 0..255
    assign ip_ok = r_item.measure_value[VAL_W-1]
                 ? ((&r_item.measure_value[VAL_W-1:8]) && (|r_item.measure_value[7:0]))
                 : (r_item.measure_value[VAL_W-1:16] == '0);
    assign ip    = r_item.measure_value[VAL_W-1] ? '0 : r_item.measure_value[15:8];

    assign fill_cur = r_sf_fill[site_idx];
    assign sf_last  = (FILL_W'(r_idx) + FILL_W'(1)) == fill_cur;
    assign sf_room  = fill_cur < FILL_W'(SF_SET_DEPTH);

    assign accept   = i_in_valid && !o_in_stall;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // shared add/compare unit
    assign alu_res  = alu_a + ((alu_op == ALU_SUB) ? ~alu_b : alu_b)
                    + ALU_W'(alu_op == ALU_SUB);
    assign alu_neg  = alu_res[ALU_W-1];
    assign alu_zero = (alu_res == '0);
    assign sum_sat  = (alu_res[ALU_W-1] != alu_res[ALU_W-2])
                    ? (alu_res[ALU_W-1] ? SUM_MIN : SUM_MAX)
                    : alu_res[SUM_W-1:0];

    // spreading factor set store
    assign sf_base   = ADDR_W'(site_idx) * ADDR_W'(SF_SET_DEPTH);
    assign ram_waddr = sf_base + ADDR_W'(fill_cur);
    assign ram_raddr = sf_base + ADDR_W'(n_idx);

    sst_ram #(
        .WIDTH (SF_W),
        .DEPTH (SF_TOTAL)
    ) u_sf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ip),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (!item_ok) begin
            kind_route = S_DONE;
        end else if (r_item.kind < KIND_BATTERY) begin
            kind_route = S_STAT_HIGH;
        end else if (r_item.kind == KIND_BATTERY) begin
            kind_route = S_BAT_FIRST;
        end else begin
            kind_route = S_SF_START;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_PER_FIRST;
            end
            S_PER_FIRST: n_state = per_en ? S_PER_LAST : kind_route;
            S_PER_LAST:  n_state = kind_route;
            S_STAT_HIGH: n_state = S_STAT_LOW;
            S_STAT_LOW:  n_state = S_STAT_SUM;
            S_STAT_SUM:  n_state = S_DONE;
            S_BAT_FIRST: n_state = r_bat_seen[site_idx] ? S_BAT_LAST : S_DONE;
            S_BAT_LAST:  n_state = S_DONE;
            S_SF_START: begin
                if (!ip_ok) begin
                    n_state = S_DONE;
                end else if (fill_cur == '0) begin
                    n_state = S_SF_WR;
                end else begin
                    n_state = S_SF_CMP;
                end
            end
            S_SF_CMP: begin
                if (alu_zero) begin
                    n_state = S_DONE;
                end else if (sf_last) begin
                    n_state = sf_room ? S_SF_WR : S_DONE;
                end
            end
            S_SF_WR: n_state = S_DONE;
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // unit operands and memory control
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        ram_we = 1'b0;
        unique case (r_state)
            S_PER_FIRST: begin
                alu_a = ext_time(r_item.time_stamp);
                alu_b = ext_time(r_per_start[src_idx]);
            end
            S_PER_LAST: begin
                alu_a = ext_time(r_per_end[src_idx]);
                alu_b = ext_time(r_item.time_stamp);
            end
            S_STAT_HIGH: begin
                alu_a = ext_val(r_stat_high_value[stat_k]);
                alu_b = ext_val(r_item.measure_value);
            end
            S_STAT_LOW: begin
                alu_a = ext_val(r_item.measure_value);
                alu_b = ext_val(r_stat_low_value[stat_k]);
            end
            S_STAT_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = {r_stat_sum[stat_k][SUM_W-1], r_stat_sum[stat_k]};
                alu_b  = ext_val(r_item.measure_value);
            end
            S_BAT_FIRST: begin
                alu_a = ext_time(r_item.time_stamp);
                alu_b = ext_time(r_bat_first_time[site_idx]);
            end
            S_BAT_LAST: begin
                alu_a = ext_time(r_bat_last_time[site_idx]);
                alu_b = ext_time(r_item.time_stamp);
            end
            S_SF_CMP: begin
                alu_a = ext_sf(ram_rdata);
                alu_b = ext_sf(ip);
            end
            S_SF_WR: ram_we = 1'b1;
            default: ;
        endcase
    end

    // set walk index, one ahead of the registered read
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_SF_START) begin
            n_idx = '0;
        end else if (r_state == S_SF_CMP && !alu_zero && !sf_last) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // result assembly
    always_comb begin
        n_out_rsp             = '0;
        n_out_rsp.accepted    = item_ok;
        n_out_rsp.sf_recorded = r_sf_rec;
        if (item_ok && r_item.kind < KIND_BATTERY) begin
            n_out_rsp.low_value     = r_stat_low_value[stat_k];
            n_out_rsp.low_time      = r_stat_low_time[stat_k];
            n_out_rsp.high_value    = r_stat_high_value[stat_k];
            n_out_rsp.high_time     = r_stat_high_time[stat_k];
            n_out_rsp.running_sum   = r_stat_sum[stat_k];
            n_out_rsp.running_count = r_stat_count[stat_k];
        end else if (item_ok && r_item.kind == KIND_BATTERY) begin
            n_out_rsp.low_value  = r_bat_first_value[site_idx];
            n_out_rsp.low_time   = r_bat_first_time[site_idx];
            n_out_rsp.high_value = r_bat_last_value[site_idx];
            n_out_rsp.high_time  = r_bat_last_time[site_idx];
        end
        if (site_ok) n_out_rsp.distinct_count = DIST_W'(fill_cur);
        if (src_ok) begin
            n_out_rsp.period_first = r_per_start[src_idx];
            n_out_rsp.period_last  = r_per_end[src_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sf_rec    <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < STAT_SLOTS; i++) begin
                r_stat_low_value[i]  <= {1'b0, {(VAL_W-1){1'b1}}};
                r_stat_low_time[i]   <= '0;
                r_stat_high_value[i] <= {1'b1, {(VAL_W-1){1'b0}}};
                r_stat_high_time[i]  <= '0;
                r_stat_sum[i]        <= '0;
                r_stat_count[i]      <= '0;
            end
            for (int i = 0; i < SITE_COUNT; i++) begin
                r_bat_seen[i]        <= 1'b0;
                r_bat_first_value[i] <= '0;
                r_bat_first_time[i]  <= '0;
                r_bat_last_value[i]  <= '0;
                r_bat_last_time[i]   <= '0;
                r_sf_fill[i]         <= '0;
            end
            for (int i = 0; i < SOURCE_COUNT; i++) begin
                r_per_seen[i]  <= 1'b0;
                r_per_start[i] <= '0;
                r_per_end[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) r_sf_rec <= 1'b0;
            unique case (r_state)
                S_PER_FIRST: begin
                    if (per_en && (!r_per_seen[src_idx] || alu_neg)) begin
                        r_per_start[src_idx] <= r_item.time_stamp;
                    end
                end
                S_PER_LAST: begin
                    if (!r_per_seen[src_idx] || alu_neg) begin
                        r_per_end[src_idx] <= r_item.time_stamp;
                    end
                    r_per_seen[src_idx] <= 1'b1;
                end
                S_STAT_HIGH: begin
                    if (stat_first || alu_neg) begin
                        r_stat_high_value[stat_k] <= r_item.measure_value;
                        r_stat_high_time[stat_k]  <= r_item.time_stamp;
                    end
                end
                S_STAT_LOW: begin
                    if (stat_first || alu_neg) begin
                        r_stat_low_value[stat_k] <= r_item.measure_value;
                        r_stat_low_time[stat_k]  <= r_item.time_stamp;
                    end
                end
                S_STAT_SUM: begin
                    r_stat_sum[stat_k] <= sum_sat;
                    if (r_stat_count[stat_k] != '1) begin
                        r_stat_count[stat_k] <= r_stat_count[stat_k] + CNT_W'(1);
                    end
                end
                S_BAT_FIRST: begin
                    if (!r_bat_seen[site_idx]) begin
                        r_bat_seen[site_idx]        <= 1'b1;
                        r_bat_first_value[site_idx] <= r_item.measure_value;
                        r_bat_first_time[site_idx]  <= r_item.time_stamp;
                        r_bat_last_value[site_idx]  <= r_item.measure_value;
                        r_bat_last_time[site_idx]   <= r_item.time_stamp;
                    end else if (alu_neg) begin
                        r_bat_first_value[site_idx] <= r_item.measure_value;
                        r_bat_first_time[site_idx]  <= r_item.time_stamp;
                    end
                end
                S_BAT_LAST: begin
                    if (alu_neg) begin
                        r_bat_last_value[site_idx] <= r_item.measure_value;
                        r_bat_last_time[site_idx]  <= r_item.time_stamp;
                    end
                end
                S_SF_WR: begin
                    r_sf_fill[site_idx] <= fill_cur + FILL_W'(1);
                    r_sf_rec            <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_req;
        if (load_out) r_out_rsp <= n_out_rsp;
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    `SST_ASSERT(a_sf_write_room, (r_state == S_SF_WR) |-> (fill_cur < FILL_W'(SF_SET_DEPTH)), "set write with no room")
    `SST_ASSERT(a_sf_walk_in_set, (r_state == S_SF_CMP) |-> (FILL_W'(r_idx) < fill_cur), "set walk past fill")
    `SST_ASSERT_NEXT(a_result_held, r_state == S_DONE && r_out_valid && i_out_stall, r_state == S_DONE, "result dropped")
    `SST_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == S_PER_FIRST, "request not started")

endmodule

FILE: rtl/sst_ram.sv
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import sst_pkg::*;

    localparam logic [2:0] KIND_TEMP    = 3'd0;
    localparam logic [2:0] KIND_HUMID   = 3'd1;
    localparam logic [2:0] KIND_PRESS   = 3'd2;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    localparam int          STAT_SLOTS   = SITE_COUNT_DEF * STAT_KINDS;
    localparam longint      SUM_TOP      = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint      SUM_BOTTOM   = -(longint'(1) <<< (SUM_W - 1));
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          QUIET_ITEMS  = 100;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_req req;
        logic fixed_exp;
        t_rsp want;
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_req    = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_rsp;

    // predictor state
    int                st_low_val  [STAT_SLOTS];
    logic [TIME_W-1:0] st_low_ts   [STAT_SLOTS];
    int                st_high_val [STAT_SLOTS];
    logic [TIME_W-1:0] st_high_ts  [STAT_SLOTS];
    longint            st_sum      [STAT_SLOTS];
    int unsigned       st_cnt      [STAT_SLOTS];
    bit                bat_seen      [SITE_COUNT_DEF];
    int                bat_first_val [SITE_COUNT_DEF];
    logic [TIME_W-1:0] bat_first_ts  [SITE_COUNT_DEF];
    int                bat_last_val  [SITE_COUNT_DEF];
    logic [TIME_W-1:0] bat_last_ts   [SITE_COUNT_DEF];
    logic [SF_W-1:0]   sf_set        [SITE_COUNT_DEF][SF_SET_DEPTH_DEF];
    int unsigned       sf_fill_cnt   [SITE_COUNT_DEF];
    bit                per_seen  [SOURCE_COUNT_DEF];
    logic [TIME_W-1:0] per_first [SOURCE_COUNT_DEF];
    logic [TIME_W-1:0] per_last  [SOURCE_COUNT_DEF];

    t_rsp              reports_due [$];
    t_stim_row         stim_rows   [$];
    logic [TIME_W-1:0] ts_clock    = 40'd1000;
    bit                gaps_on     = 1'b1;
    int unsigned       stall_left  = 0;
    int unsigned       cycle_cnt   = 0;
    int                mismatch_cnt = 0;

    sensor_stats_tracker dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_stall,
        .i_in_req,
        .o_out_valid,
        .i_out_stall,
        .o_out_rsp
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_rsp track_measurement(input t_req r);
        t_rsp        o;
        int unsigned slot;
        int unsigned n;
        int          v;
        longint      acc;
        longint      ip;
        bit          first;
        bit          found;
        o = '0;
        v = r.measure_value;
        if (r.kind <= KIND_SF) begin
            o.accepted = 1'b1;
            if (!per_seen[r.source_file] || r.time_stamp < per_first[r.source_file])
                per_first[r.source_file] = r.time_stamp;
            if (!per_seen[r.source_file] || r.time_stamp > per_last[r.source_file])
                per_last[r.source_file] = r.time_stamp;
            per_seen[r.source_file] = 1'b1;
            if (r.kind < KIND_BATTERY) begin
                slot  = STAT_KINDS * r.site + r.kind;
                first = (st_cnt[slot] == 0);
                if (first || v > st_high_val[slot]) begin
                    st_high_val[slot] = v;
                    st_high_ts[slot]  = r.time_stamp;
                end
                if (first || v < st_low_val[slot]) begin
                    st_low_val[slot] = v;
                    st_low_ts[slot]  = r.time_stamp;
                end
                acc = st_sum[slot] + longint'(v);
                if (acc > SUM_TOP)
                    acc = SUM_TOP;
                if (acc < SUM_BOTTOM)
                    acc = SUM_BOTTOM;
                st_sum[slot] = acc;
                if (st_cnt[slot] != 32'hFFFF_FFFF)
                    st_cnt[slot] = st_cnt[slot] + 1;
                o.low_value     = st_low_val[slot];
                o.low_time      = st_low_ts[slot];
                o.high_value    = st_high_val[slot];
                o.high_time     = st_high_ts[slot];
                o.running_sum   = acc[SUM_W-1:0];
                o.running_count = st_cnt[slot];
            end else if (r.kind == KIND_BATTERY) begin
                if (!bat_seen[r.site]) begin
                    bat_first_val[r.site] = v;
                    bat_first_ts[r.site]  = r.time_stamp;
                    bat_last_val[r.site]  = v;
                    bat_last_ts[r.site]   = r.time_stamp;
                    bat_seen[r.site]      = 1'b1;
                end else begin
                    if (r.time_stamp < bat_first_ts[r.site]) begin
                        bat_first_val[r.site] = v;
                        bat_first_ts[r.site]  = r.time_stamp;
                    end
                    if (r.time_stamp > bat_last_ts[r.site]) begin
                        bat_last_val[r.site] = v;
                        bat_last_ts[r.site]  = r.time_stamp;
                    end
                end
                o.low_value  = bat_first_val[r.site];
                o.low_time   = bat_first_ts[r.site];
                o.high_value = bat_last_val[r.site];
                o.high_time  = bat_last_ts[r.site];
            end else begin
                // integer part, truncated toward zero
                ip = longint'(v) / 256;
                if (ip >= 0 && ip <= 255) begin
                    n     = sf_fill_cnt[r.site];
                    found = 1'b0;
                    for (int i = 0; i < n; i++)
                        if (sf_set[r.site][i] == ip[SF_W-1:0])
                            found = 1'b1;
                    if (!found && n < SF_SET_DEPTH_DEF) begin
                        sf_set[r.site][n]     = ip[SF_W-1:0];
                        sf_fill_cnt[r.site]   = n + 1;
                        o.sf_recorded         = 1'b1;
                    end
                end
            end
        end
        o.distinct_count = DIST_W'(sf_fill_cnt[r.site]);
        o.period_first   = per_first[r.source_file];
        o.period_last    = per_last[r.source_file];
        return o;
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return TIME_W'({$urandom, $urandom});
        if (pick < 14)
            return ts_clock;
        if (pick < 20)
            return ts_clock - TIME_W'($urandom_range(1, 500));
        ts_clock = ts_clock + TIME_W'($urandom_range(1, 60));
        return ts_clock;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        r.site        = 1'($urandom_range(0, 1));
        r.source_file = 1'($urandom_range(0, 1));
        r.time_stamp  = next_stamp();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.kind = 3'($urandom_range(5, 7));
        else if (pick < 30)
            r.kind = KIND_SF;
        else if (pick < 42)
            r.kind = KIND_BATTERY;
        else
            r.kind = 3'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            r.measure_value = $urandom;
        end else if (pick < 22) begin
            case ($urandom_range(0, 3))
                0: r.measure_value = 32'sh7FFF_FFFF;
                1: r.measure_value = 32'h8000_0000;
                2: r.measure_value = '0;
                default: r.measure_value = '1;
            endcase
        end else if (r.kind == KIND_SF) begin
            if (pick < 90)
                r.measure_value = {16'h0000, 8'($urandom_range(0, 19)), 8'($urandom)};
            else
                r.measure_value = {16'h0000, 8'($urandom), 8'($urandom)};
        end else begin
            r.measure_value = $signed(32'($urandom_range(0, 40000))) - 32'sd20000;
        end
        return r;
    endfunction

    task automatic add_row(input logic site, input logic [2:0] kind, input logic [31:0] val,
                           input logic [TIME_W-1:0] ts, input logic src, input logic fixed_exp,
                           input t_rsp want);
        t_stim_row row;
        row.req.site          = site;
        row.req.kind          = kind;
        row.req.measure_value = val;
        row.req.time_stamp    = ts;
        row.req.source_file   = src;
        row.fixed_exp         = fixed_exp;
        row.want              = want;
        stim_rows.push_back(row);
    endtask

    // entered and left at a falling edge
    task automatic send_request(input t_req r, input logic fixed_exp, input t_rsp want);
        t_rsp predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        predicted = track_measurement(r);
        reports_due.push_back(fixed_exp ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch in %s at cycle %0d: expected %h, got %h",
                         fname, cycle_cnt, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (gaps_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        i_out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result at cycle %0d: %h", cycle_cnt, o_out_rsp);
            end else begin
                want = reports_due.pop_front();
                check_field("accepted", 64'(o_out_rsp.accepted), 64'(want.accepted));
                check_field("sf_recorded", 64'(o_out_rsp.sf_recorded),
                            64'(want.sf_recorded));
                check_field("low_value", 64'(o_out_rsp.low_value), 64'(want.low_value));
                check_field("low_time", 64'(o_out_rsp.low_time), 64'(want.low_time));
                check_field("high_value", 64'(o_out_rsp.high_value), 64'(want.high_value));
                check_field("high_time", 64'(o_out_rsp.high_time), 64'(want.high_time));
                check_field("running_sum", 64'(o_out_rsp.running_sum),
                            64'(want.running_sum));
                check_field("running_count", 64'(o_out_rsp.running_count),
                            64'(want.running_count));
                check_field("distinct_count", 64'(o_out_rsp.distinct_count),
                            64'(want.distinct_count));
                check_field("period_first", 64'(o_out_rsp.period_first),
                            64'(want.period_first));
                check_field("period_last", 64'(o_out_rsp.period_last),
                            64'(want.period_last));
            end
        end
    end

    initial begin
        t_req r;
        int   sent;
        for (int i = 0; i < STAT_SLOTS; i++) begin
            st_low_val[i]  = 32'sh7FFF_FFFF;
            st_high_val[i] = 32'sh8000_0000;
            st_low_ts[i]   = '0;
            st_high_ts[i]  = '0;
            st_sum[i]      = 0;
            st_cnt[i]      = 0;
        end
        for (int i = 0; i < SITE_COUNT_DEF; i++) begin
            bat_seen[i]      = 1'b0;
            bat_first_val[i] = 0;
            bat_first_ts[i]  = '0;
            bat_last_val[i]  = 0;
            bat_last_ts[i]   = '0;
            sf_fill_cnt[i]   = 0;
        end
        for (int i = 0; i < SOURCE_COUNT_DEF; i++) begin
            per_seen[i]  = 1'b0;
            per_first[i] = '0;
            per_last[i]  = '0;
        end

        // first statistic at a reset value, extremes, ties
        add_row(1'b0, KIND_TEMP, 32'h7FFF_FFFF, 40'd100, 1'b0, 1'b1,
                {1'b1, 1'b0, 32'h7FFF_FFFF, 40'd100, 32'h7FFF_FFFF, 40'd100,
                 48'h0000_7FFF_FFFF, 32'd1, 5'd0, 40'd100, 40'd100});
        add_row(1'b0, KIND_TEMP, 32'h8000_0000, 40'd100, 1'b0, 1'b1,
                {1'b1, 1'b0, 32'h8000_0000, 40'd100, 32'h7FFF_FFFF, 40'd100,
                 48'hFFFF_FFFF_FFFF, 32'd2, 5'd0, 40'd100, 40'd100});
        add_row(1'b0, KIND_TEMP, 32'h7FFF_FFFF, 40'd200, 1'b0, 1'b0, '0);
        add_row(1'b1, KIND_HUMID, 32'h8000_0000, 40'd0, 1'b1, 1'b1,
                {1'b1, 1'b0, 32'h8000_0000, 40'd0, 32'h8000_0000, 40'd0,
                 48'hFFFF_8000_0000, 32'd1, 5'd0, 40'd0, 40'd0});
        add_row(1'b1, KIND_PRESS, 32'h0, 40'hFF_FFFF_FFFF, 1'b1, 1'b1,
                {1'b1, 1'b0, 32'h0, 40'hFF_FFFF_FFFF, 32'h0, 40'hFF_FFFF_FFFF,
                 48'h0, 32'd1, 5'd0, 40'd0, 40'hFF_FFFF_FFFF});
        // battery: first, equal stamp, earlier, later
        add_row(1'b0, KIND_BATTERY, 32'h100, 40'd500, 1'b0, 1'b1,
                {1'b1, 1'b0, 32'h100, 40'd500, 32'h100, 40'd500,
                 48'h0, 32'd0, 5'd0, 40'd100, 40'd500});
        add_row(1'b0, KIND_BATTERY, 32'h200, 40'd500, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_BATTERY, 32'h50, 40'd50, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_BATTERY, 32'h300, 40'd600, 1'b0, 1'b0, '0);
        // spreading factor: new, repeat, small negative, top, out of range
        add_row(1'b0, KIND_SF, 32'h0C00, 40'd600, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_SF, 32'h0CFF, 40'd600, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_SF, 32'hFFFF_FFFF, 40'd600, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_SF, 32'h0000_FFFF, 40'd600, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_SF, 32'h0001_0000, 40'd600, 1'b0, 1'b1,
                {1'b1, 1'b0, 32'h0, 40'd0, 32'h0, 40'd0,
                 48'h0, 32'd0, 5'd3, 40'd50, 40'd600});
        add_row(1'b0, KIND_SF, 32'hFFFF_FF00, 40'd600, 1'b0, 1'b1,
                {1'b1, 1'b0, 32'h0, 40'd0, 32'h0, 40'd0,
                 48'h0, 32'd0, 5'd3, 40'd50, 40'd600});
        // ignored kinds, then further statistic rows
        add_row(1'b0, KIND_IGNORED, 32'h1234, 40'd10, 1'b0, 1'b1,
                {1'b0, 1'b0, 32'h0, 40'd0, 32'h0, 40'd0,
                 48'h0, 32'd0, 5'd3, 40'd50, 40'd600});
        add_row(1'b1, 3'd7, 32'hFFFF_FFFF, 40'd3, 1'b1, 1'b1,
                {1'b0, 1'b0, 32'h0, 40'd0, 32'h0, 40'd0,
                 48'h0, 32'd0, 5'd0, 40'd0, 40'hFF_FFFF_FFFF});
        add_row(1'b0, 3'd6, 32'h8000_0000, 40'hFF_FFFF_FFFF, 1'b1, 1'b0, '0);
        add_row(1'b1, KIND_TEMP, 32'h8000_0000, 40'd7, 1'b0, 1'b0, '0);
        add_row(1'b1, KIND_TEMP, 32'h7FFF_FFFF, 40'd7, 1'b0, 1'b0, '0);
        add_row(1'b0, KIND_HUMID, 32'h1234_5678, 40'hAA_5555_AAAA, 1'b1, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_request(stim_rows[i].req, stim_rows[i].fixed_exp, stim_rows[i].want);

        // random traffic, the last stretch without idling
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                gaps_on = 1'b0;
            else if (sent % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            r = random_request();
            sent++;
            send_request(r, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && reports_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
